@@ rtl/relt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relt_pkg
// Shared types and constants for the ring event log table.
// ----------------------------------------------------------------------------
package relt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 16;
    localparam int LOC_W     = 64;
    localparam int NUM_W     = 16;
    localparam int CNT_W     = 5;
    localparam int ACT_W     = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ADD,
        WR_WIPE,
        WR_SWEEP
    } t_wr_sel;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_FIND,
        RD_SCAN,
        RD_FETCH
    } t_rd_op;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LOC_W-1:0] loc;
        logic [NUM_W-1:0] num;
    } t_entry;

    typedef struct packed {
        logic    load;
        t_wr_sel wr_sel;
        t_rd_op  rd_op;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic match_hit;
    } t_sts;

endpackage

@@ rtl/ring_event_log_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_event_log_table_unit
// Ring of DEPTH log entries (id, location word, sequence number) with add,
// remove by number, clear and query actions.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the action and its fields and raise start; the word is taken at a
//   rising edge where start is high and busy is low. busy stays high while
//   the entry memory is walked.
//   One result word follows each action, shown for exactly one cycle with
//   o_done high; it describes the table after the action.
//   Steps per action: a query scans the table; an add writes the entry,
//   then scans; a clear sweeps every entry, then scans; a remove searches,
//   wipes the first match if any, then scans. The entry memory has a single
//   read port and is walked one entry per cycle for the search, sweep and
//   scan passes. A new word may be taken in the o_done cycle.
//   i_cfg_we writes the location word used for emptied entries; write it
//   only while busy is low.
//   Reset (synchronous, active low) empties all entries, sets the ring
//   pointer to 0 and the next sequence number to 1. There is no clearing
//   pass: per-entry valid bits make every entry read as zero.
//   The receiver cannot stall; a result must be taken in its o_done cycle.
// ----------------------------------------------------------------------------
module ring_event_log_table_unit
    import relt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [ACT_W-1:0] i_action,
    input  logic [ID_W-1:0]  i_entry_id,
    input  logic [LOC_W-1:0] i_entry_location,
    input  logic [NUM_W-1:0] i_target_number,
    input  logic             i_cfg_we,
    input  logic [LOC_W-1:0] i_cfg_data,
    output logic             o_done,
    output logic [NUM_W-1:0] o_removed_number,
    output logic [CNT_W-1:0] o_occupied_count,
    output logic [ID_W-1:0]  o_found_id,
    output logic [LOC_W-1:0] o_found_location,
    output logic [NUM_W-1:0] o_found_number
);

    localparam int AW = $clog2(DEPTH);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [AW-1:0] w_addr;

    relt_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (t_action'(i_action)),
        .i_sts    (w_sts),
        .o_busy   (busy),
        .o_cmd    (w_cmd),
        .o_addr   (w_addr)
    );

    relt_dpath #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_addr           (w_addr),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_entry_id       (i_entry_id),
        .i_entry_location (i_entry_location),
        .i_target_number  (i_target_number),
        .o_sts            (w_sts),
        .o_done           (o_done),
        .o_removed_number (o_removed_number),
        .o_occupied_count (o_occupied_count),
        .o_found_id       (o_found_id),
        .o_found_location (o_found_location),
        .o_found_number   (o_found_number)
    );

endmodule

@@ rtl/relt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relt_ctrl
// Sequencer: walks the entry index for search, sweep and scan passes and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
module relt_ctrl
    import relt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_action       i_action,
    input  t_sts          i_sts,
    output logic          o_busy,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_addr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_FIND,
        S_FIND_END,
        S_WIPE,
        S_SWEEP,
        S_SCAN,
        S_SCAN_END,
        S_FETCH,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          w_last;
    logic          w_accept;

    assign w_last   = (r_cnt == AW'(DEPTH - 1));
    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);
    assign o_addr   = r_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd.load   = 1'b0;
        o_cmd.wr_sel = WR_NONE;
        o_cmd.rd_op  = RD_NONE;
        o_cmd.emit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        ACT_ADD:    n_state = S_ADD;
                        ACT_REMOVE: n_state = S_FIND;
                        ACT_CLEAR:  n_state = S_SWEEP;
                        ACT_QUERY:  n_state = S_SCAN;
                        default:    n_state = S_SCAN;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.wr_sel = WR_ADD;
                n_state      = S_SCAN;
            end
            S_FIND: begin
                o_cmd.rd_op = RD_FIND;
                n_cnt       = r_cnt + AW'(1);
                if (w_last) begin
                    n_state = S_FIND_END;
                end
            end
            S_FIND_END: begin
                n_cnt   = '0;
                n_state = i_sts.match_hit ? S_WIPE : S_SCAN;
            end
            S_WIPE: begin
                o_cmd.wr_sel = WR_WIPE;
                n_state      = S_SCAN;
            end
            S_SWEEP: begin
                o_cmd.wr_sel = WR_SWEEP;
                n_cnt        = r_cnt + AW'(1);
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_op = RD_SCAN;
                n_cnt       = r_cnt + AW'(1);
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.rd_op = RD_FETCH;
                n_state     = S_DONE;
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy)
        else $error("accepted word did not make the block busy");

    a_wipe_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WIPE) |-> i_sts.match_hit)
        else $error("wipe issued without a match");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("controller not idle after result");

    a_pass_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state == S_SCAN) || $rose(r_state == S_FIND)
            || $rose(r_state == S_SWEEP)) |-> (r_cnt == '0))
        else $error("pass did not start at entry zero");
`endif

endmodule

@@ rtl/relt_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relt_dpath
// Entry memory, ring pointer, sequence counter, scan accumulators and the
// result registers.
// ----------------------------------------------------------------------------
module relt_dpath
    import relt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [AW-1:0]    i_addr,
    input  logic             i_cfg_we,
    input  logic [LOC_W-1:0] i_cfg_data,
    input  logic [ID_W-1:0]  i_entry_id,
    input  logic [LOC_W-1:0] i_entry_location,
    input  logic [NUM_W-1:0] i_target_number,
    output t_sts             o_sts,
    output logic             o_done,
    output logic [NUM_W-1:0] o_removed_number,
    output logic [CNT_W-1:0] o_occupied_count,
    output logic [ID_W-1:0]  o_found_id,
    output logic [LOC_W-1:0] o_found_location,
    output logic [NUM_W-1:0] o_found_number
);

    t_entry             mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [AW-1:0]      r_ptr;
    logic [NUM_W-1:0]   r_next;
    logic [LOC_W-1:0]   r_empty_loc;

    logic [ID_W-1:0]    r_id;
    logic [LOC_W-1:0]   r_loc;
    logic [NUM_W-1:0]   r_target;

    t_entry             r_rd_word;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_addr;
    t_rd_op             r_rd_op;

    logic               r_match_hit;
    logic [AW-1:0]      r_match_idx;
    logic [NUM_W-1:0]   r_removed;
    logic [CNT_W-1:0]   r_count;
    logic [AW-1:0]      r_pick;

    logic               r_done;
    logic [NUM_W-1:0]   r_o_removed;
    logic [CNT_W-1:0]   r_o_count;
    t_entry             r_o_entry;

    logic               w_we;
    logic [AW-1:0]      w_wa;
    t_entry             w_wd;
    logic [AW-1:0]      w_ra;
    t_entry             w_rd;
    logic               w_find_hit;

    assign w_rd       = r_rd_vld ? r_rd_word : '0;
    assign w_ra       = (i_cmd.rd_op == RD_FETCH) ? r_pick : i_addr;
    assign w_find_hit = (r_rd_op == RD_FIND) && (w_rd.num == r_target);

    always_comb begin
        w_we = 1'b1;
        w_wa = i_addr;
        w_wd = '{id: '0, loc: r_empty_loc, num: '0};
        case (i_cmd.wr_sel)
            WR_ADD: begin
                w_wa = r_ptr;
                w_wd = '{id: r_id, loc: r_loc, num: r_next};
            end
            WR_WIPE: begin
                w_wa = r_match_idx;
            end
            WR_SWEEP: begin
                w_wa = i_addr;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // entry storage with registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd_word <= mem[w_ra];
        r_rd_addr <= w_ra;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id     <= i_entry_id;
            r_loc    <= i_entry_location;
            r_target <= i_target_number;
        end
        if (i_cmd.emit) begin
            r_o_removed <= r_removed;
            r_o_count   <= r_count;
            r_o_entry   <= w_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_ptr       <= '0;
            r_next      <= NUM_W'(1);
            r_empty_loc <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_op     <= RD_NONE;
            r_match_hit <= 1'b0;
            r_match_idx <= '0;
            r_removed   <= '0;
            r_count     <= '0;
            r_pick      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done   <= i_cmd.emit;
            r_rd_op  <= i_cmd.rd_op;
            r_rd_vld <= r_vld[w_ra];
            if (i_cfg_we) begin
                r_empty_loc <= i_cfg_data;
            end
            if (w_we) begin
                r_vld[w_wa] <= 1'b1;
            end
            if (i_cmd.wr_sel == WR_ADD) begin
                r_next <= r_next + NUM_W'(1);
                r_ptr  <= (r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + AW'(1);
            end
            if (i_cmd.wr_sel == WR_SWEEP) begin
                r_next <= NUM_W'(1);
            end
            if (i_cmd.wr_sel == WR_WIPE) begin
                r_removed <= r_target;
            end
            if (i_cmd.load) begin
                r_match_hit <= 1'b0;
                r_removed   <= '0;
                r_count     <= '0;
                r_pick      <= '0;
            end else begin
                // first match wins
                if (w_find_hit && !r_match_hit) begin
                    r_match_hit <= 1'b1;
                    r_match_idx <= r_rd_addr;
                end
                if (r_rd_op == RD_SCAN && w_rd.id != '0) begin
                    r_count <= r_count + CNT_W'(1);
                    r_pick  <= r_rd_addr;
                end
            end
        end
    end

    // last entry of the search is compared in the same cycle the status is used
    assign o_sts.match_hit  = r_match_hit || w_find_hit;
    assign o_done           = r_done;
    assign o_removed_number = r_o_removed;
    assign o_occupied_count = r_o_count;
    assign o_found_id       = r_o_entry.id;
    assign o_found_location = r_o_entry.loc;
    assign o_found_number   = r_o_entry.num;

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= AW'(DEPTH - 1))
        else $error("ring pointer out of range");

    a_add_numbering: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_sel == WR_ADD) |=> (r_next == $past(r_next) + NUM_W'(1)))
        else $error("sequence number did not advance on add");

    a_removed_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_removed != '0) |-> r_match_hit)
        else $error("removed number without a match");
`endif

endmodule

@@ sim/tb_ring_event_log_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_event_log_table_unit
// Self-checking bench for the ring event log table. A scoreboard class keeps
// its own copy of the ring, the sequence counter and the empty-location
// register. It predicts one result word per accepted action and compares every
// o_done word with the oldest prediction, field by field. Stimulus is a short
// directed run over the corner cases, then random bursts (most with random gaps)
// under several empty-location settings.
// ----------------------------------------------------------------------------
module tb_ring_event_log_table_unit;
    import relt_pkg::*;

    localparam int TB_DEPTH       = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int NUM_SPACE      = 1 << NUM_W;

    typedef struct packed {
        t_action          act;
        logic [ID_W-1:0]  id;
        logic [LOC_W-1:0] loc;
        logic [NUM_W-1:0] target;
    } log_word_t;

    typedef struct packed {
        logic [NUM_W-1:0] removed;
        logic [CNT_W-1:0] count;
        logic [ID_W-1:0]  id;
        logic [LOC_W-1:0] loc;
        logic [NUM_W-1:0] num;
    } log_result_t;

    class ring_log_scoreboard;
        logic [ID_W-1:0]  slot_id  [TB_DEPTH];
        logic [LOC_W-1:0] slot_loc [TB_DEPTH];
        logic [NUM_W-1:0] slot_num [TB_DEPTH];
        int unsigned      write_ptr;
        logic [NUM_W-1:0] next_num;
        logic [LOC_W-1:0] blank_loc;
        log_result_t      expected_q[$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      action_hits[4];
        int unsigned      remove_hits;
        int unsigned      number_wraps;

        function new();
            int k;
            for (k = 0; k < TB_DEPTH; k++) begin
                slot_id[k]  = '0;
                slot_loc[k] = '0;
                slot_num[k] = '0;
            end
            write_ptr    = 0;
            next_num     = NUM_W'(1);
            blank_loc    = '0;
            errors       = 0;
            checked      = 0;
            remove_hits  = 0;
            number_wraps = 0;
            for (k = 0; k < 4; k++) action_hits[k] = 0;
        endfunction

        function void set_blank_loc(logic [LOC_W-1:0] v);
            blank_loc = v;
        endfunction

        function void wipe_slot(int k);
            slot_id[k]  = '0;
            slot_loc[k] = blank_loc;
            slot_num[k] = '0;
        endfunction

        function logic [NUM_W-1:0] some_number();
            return slot_num[$urandom_range(0, TB_DEPTH - 1)];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(log_word_t w);
            log_result_t r;
            int          k;
            int          pick;
            int          hits;
            bit          matched;
            r       = '0;
            pick    = 0;
            hits    = 0;
            matched = 1'b0;
            action_hits[int'(w.act)]++;
            case (w.act)
                ACT_ADD: begin
                    slot_id[write_ptr]  = w.id;
                    slot_loc[write_ptr] = w.loc;
                    slot_num[write_ptr] = next_num;
                    next_num = next_num + 1'b1;
                    if (next_num == '0) number_wraps++;
                    write_ptr = (write_ptr == TB_DEPTH - 1) ? 0 : write_ptr + 1;
                end
                ACT_REMOVE: begin
                    for (k = 0; k < TB_DEPTH; k++) begin
                        if (!matched && slot_num[k] == w.target) begin
                            wipe_slot(k);
                            matched   = 1'b1;
                            r.removed = w.target;
                        end
                    end
                    if (matched) remove_hits++;
                end
                ACT_CLEAR: begin
                    for (k = 0; k < TB_DEPTH; k++) wipe_slot(k);
                    next_num = NUM_W'(1);
                end
                default: ;
            endcase
            for (k = 0; k < TB_DEPTH; k++) begin
                if (slot_id[k] != '0) begin
                    hits++;
                    pick = k;
                end
            end
            r.count = hits[CNT_W-1:0];
            r.id    = slot_id[pick];
            r.loc   = slot_loc[pick];
            r.num   = slot_num[pick];
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch at result %0d: %s", $time, checked, msg);
            errors++;
        endtask

        task check_result(log_result_t got);
            log_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result word with none expected, count %0d id %h",
                    got.count, got.id));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.removed !== want.removed)
                report_mismatch($sformatf("removed_number got %h want %h",
                    got.removed, want.removed));
            if (got.count !== want.count)
                report_mismatch($sformatf("occupied_count got %0d want %0d",
                    got.count, want.count));
            if (got.id !== want.id)
                report_mismatch($sformatf("found_id got %h want %h", got.id, want.id));
            if (got.loc !== want.loc)
                report_mismatch($sformatf("found_location got %h want %h", got.loc, want.loc));
            if (got.num !== want.num)
                report_mismatch($sformatf("found_number got %h want %h", got.num, want.num));
        endtask

        task flush_check();
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d result words never arrived", expected_q.size()));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [ACT_W-1:0] i_action;
    logic [ID_W-1:0]  i_entry_id;
    logic [LOC_W-1:0] i_entry_location;
    logic [NUM_W-1:0] i_target_number;
    logic             i_cfg_we;
    logic [LOC_W-1:0] i_cfg_data;
    logic             o_done;
    logic [NUM_W-1:0] o_removed_number;
    logic [CNT_W-1:0] o_occupied_count;
    logic [ID_W-1:0]  o_found_id;
    logic [LOC_W-1:0] o_found_location;
    logic [NUM_W-1:0] o_found_number;

    ring_log_scoreboard sb = new();
    log_result_t        seen;
    int                 quiet_cycles = 0;
    int                 k_dir;

    ring_event_log_table_unit #(
        .DEPTH (TB_DEPTH)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_entry_id       (i_entry_id),
        .i_entry_location (i_entry_location),
        .i_target_number  (i_target_number),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_removed_number (o_removed_number),
        .o_occupied_count (o_occupied_count),
        .o_found_id       (o_found_id),
        .o_found_location (o_found_location),
        .o_found_number   (o_found_number)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // results checked at the rising edge; quiet cycles also feed the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                seen.removed = o_removed_number;
                seen.count   = o_occupied_count;
                seen.id      = o_found_id;
                seen.loc     = o_found_location;
                seen.num     = o_found_number;
                sb.check_result(seen);
            end
            if (o_done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic log_word_t mk(t_action a, logic [ID_W-1:0] id,
                                     logic [LOC_W-1:0] loc, logic [NUM_W-1:0] tgt);
        log_word_t w;
        w.act    = a;
        w.id     = id;
        w.loc    = loc;
        w.target = tgt;
        return w;
    endfunction

    function automatic log_word_t random_word();
        log_word_t w;
        int        roll;
        int        pick;
        roll = $urandom_range(0, 9);
        w.id = (roll == 0) ? '0 : (roll == 1) ? '1 : ID_W'($urandom);
        roll  = $urandom_range(0, 9);
        w.loc = (roll == 0) ? '0 : (roll == 1) ? '1 : {$urandom, $urandom};
        w.target = NUM_W'($urandom_range(0, NUM_SPACE - 1));
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            w.act = ACT_ADD;
        end else if (roll < 75) begin
            w.act = ACT_REMOVE;
            pick  = $urandom_range(0, 9);
            // mostly aim at a number that is really in the ring
            if (pick < 6)
                w.target = sb.some_number();
            else if (pick == 6)
                w.target = '0;
        end else if (roll < 80) begin
            w.act = ACT_CLEAR;
        end else begin
            w.act = ACT_QUERY;
        end
        return w;
    endfunction

    task automatic send_word(log_word_t w);
        @(negedge i_clk);
        start            = 1'b1;
        i_action         = w.act;
        i_entry_id       = w.id;
        i_entry_location = w.loc;
        i_target_number  = w.target;
        do @(posedge i_clk); while (busy);
        sb.note_word(w);
    endtask

    task automatic pause(int n);
        repeat (n) begin
            @(negedge i_clk);
            start            = 1'b0;
            i_action         = ACT_W'($urandom_range(0, 3));
            i_entry_id       = ID_W'($urandom);
            i_entry_location = {$urandom, $urandom};
            i_target_number  = NUM_W'($urandom);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_blank_loc(logic [LOC_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        sb.set_blank_loc(v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_random(int n_items, bit with_gaps);
        int left;
        int burst;
        left = n_items;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                send_word(random_word());
                burst--;
                left--;
            end
            if (with_gaps && $urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_action         = ACT_QUERY;
        i_entry_id       = '0;
        i_entry_location = '0;
        i_target_number  = '0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corner cases
        write_blank_loc(64'hA5A5_0F0F_C3C3_5A5A);
        send_word(mk(ACT_QUERY, '0, '0, '0));
        send_word(mk(ACT_REMOVE, '0, '0, '0));
        send_word(mk(ACT_ADD, '1, '1, '0));
        send_word(mk(ACT_ADD, '0, 64'h0123_4567_89AB_CDEF, '1));
        send_word(mk(ACT_ADD, 16'd1, '0, '0));
        send_word(mk(ACT_REMOVE, '1, '1, 16'd2));
        send_word(mk(ACT_REMOVE, '0, '0, 16'h1234));
        for (k_dir = 0; k_dir < 14; k_dir++)
            send_word(mk(ACT_ADD, ID_W'(k_dir + 2), {$urandom, $urandom}, '0));
        send_word(mk(ACT_REMOVE, '0, '0, '1));
        send_word(mk(ACT_CLEAR, '1, '1, '1));
        send_word(mk(ACT_QUERY, '1, '1, '1));

        write_blank_loc('1);
        run_random(240, 1'b1);
        write_blank_loc('0);
        run_random(200, 1'b0);
        write_blank_loc({$urandom, $urandom});
        run_random(220, 1'b1);
        write_blank_loc(64'h8000_0000_0000_0001);
        run_random(200, 1'b1);

        // clear, refill a little and remove around number zero
        write_blank_loc('1);
        send_word(mk(ACT_CLEAR, '0, '0, '0));
        send_word(mk(ACT_ADD, 16'h00FF, '1, '0));
        send_word(mk(ACT_ADD, 16'hFF00, '0, '0));
        send_word(mk(ACT_REMOVE, '0, '0, '0));
        send_word(mk(ACT_QUERY, '0, '0, '0));
        send_word(mk(ACT_REMOVE, '0, '0, 16'd1));
        send_word(mk(ACT_REMOVE, '0, '0, '0));
        run_random(150, 1'b1);

        drain();
        repeat (2 * TB_DEPTH + 8) @(posedge i_clk);
        sb.flush_check();
        $display("covered %0d adds, %0d removes (%0d matched), %0d clears, %0d queries",
            sb.action_hits[ACT_ADD], sb.action_hits[ACT_REMOVE], sb.remove_hits,
            sb.action_hits[ACT_CLEAR], sb.action_hits[ACT_QUERY]);
        $display("%0d result words checked, sequence counter wrapped %0d time(s), %0d mismatches",
            sb.checked, sb.number_wraps, sb.errors);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/relt_pkg.sv
rtl/relt_ctrl.sv
rtl/relt_dpath.sv
rtl/ring_event_log_table_unit.sv
sim/tb_ring_event_log_table_unit.sv
